// File: hw/rtl/ipv4lpm_pkg.sv
package ipv4lpm_pkg;

	localparam int TABLE_ENTRIES_DEF = 256;
	localparam int LOCATION_BITS_DEF = 16;

	localparam int ADDR_W = 32;
	localparam int LEN_W  = 6;
	localparam int LOCF_W = 16;

	localparam logic [LEN_W-1:0] MAX_LEN = 6'd32;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2,
		ST_BAD  = 2'd3
	} status_t;

	typedef struct packed {
		logic load_in;
		logic rd_en;
		logic cmp_en;
		logic out_load;
		logic write;
		logic table_full;
	} dp_cmd_t;

	typedef struct packed {
		logic bad;
		logic lookup;
		logic dup;
	} dp_sts_t;

	function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
		len_mask = ~({ADDR_W{1'b1}} >> len);
	endfunction

endpackage

// File: hw/rtl/ipv4lpm_dp.sv
module ipv4lpm_dp #(
	parameter int TABLE_ENTRIES = ipv4lpm_pkg::TABLE_ENTRIES_DEF,
	parameter int LOCATION_BITS = ipv4lpm_pkg::LOCATION_BITS_DEF
) (
	input  logic                              clk,
	input  ipv4lpm_pkg::dp_cmd_t              cmd,
	output ipv4lpm_pkg::dp_sts_t              sts,
	input  logic [$clog2(TABLE_ENTRIES)-1:0]  rd_addr,
	input  logic [$clog2(TABLE_ENTRIES)-1:0]  wr_addr,
	input  logic                              op,
	input  logic [ipv4lpm_pkg::ADDR_W-1:0]    address,
	input  logic [ipv4lpm_pkg::LEN_W-1:0]     prefix_len,
	input  logic [ipv4lpm_pkg::LOCF_W-1:0]    location_id,
	output ipv4lpm_pkg::status_t              status,
	output logic [ipv4lpm_pkg::LOCF_W-1:0]    found_location,
	output logic [ipv4lpm_pkg::LEN_W-1:0]     matched_len
);

	localparam int LOC_W = LOCATION_BITS;
	localparam int AW    = ipv4lpm_pkg::ADDR_W;
	localparam int LW    = ipv4lpm_pkg::LEN_W;
	localparam int FW    = ipv4lpm_pkg::LOCF_W;
	localparam int ENT_W = AW + LW + LOC_W;

	logic [ENT_W-1:0] mem [TABLE_ENTRIES];
	logic [ENT_W-1:0] rd_q;

	logic             op_q;
	logic             bad_q;
	logic [AW-1:0]    addr_q;
	logic [AW-1:0]    key_q;
	logic [LW-1:0]    len_q;
	logic [LOC_W-1:0] loc_q;
	logic [LW-1:0]    best_len_q;
	logic [LOC_W-1:0] best_loc_q;
	logic             dup_q;

	logic [LOC_W+FW-1:0] loc_in_wide;
	logic [LOC_W+FW-1:0] best_wide;
	logic [AW-1:0]       rd_prefix;
	logic [LW-1:0]       rd_len;
	logic [LOC_W-1:0]    rd_loc;
	logic                in_bad;
	logic                is_dup;
	logic                is_better;
	logic                lookup_hit;

	assign loc_in_wide = {{LOC_W{1'b0}}, location_id};
	assign best_wide   = {{FW{1'b0}}, best_loc_q};

	assign rd_prefix = rd_q[ENT_W-1 -: AW];
	assign rd_len    = rd_q[LOC_W +: LW];
	assign rd_loc    = rd_q[LOC_W-1:0];

	assign in_bad = (address == '0) || ((op == ipv4lpm_pkg::OP_INSERT) &&
		((prefix_len == '0) || (prefix_len > ipv4lpm_pkg::MAX_LEN)));

	assign is_dup    = (rd_len == len_q) && (rd_prefix == key_q);
	assign is_better = ((addr_q & ipv4lpm_pkg::len_mask(rd_len)) == rd_prefix) &&
		(rd_len > best_len_q);

	assign lookup_hit = !bad_q && (op_q == ipv4lpm_pkg::OP_LOOKUP) && (best_len_q != '0);

	assign sts.bad    = bad_q;
	assign sts.lookup = (op_q == ipv4lpm_pkg::OP_LOOKUP);
	assign sts.dup    = dup_q;

	// prefix table, one port each way
	always_ff @(posedge clk) begin
		if (cmd.write) begin
			mem[wr_addr] <= {key_q, len_q, loc_q};
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q       <= op;
			bad_q      <= in_bad;
			addr_q     <= address;
			key_q      <= address & ipv4lpm_pkg::len_mask(prefix_len);
			len_q      <= prefix_len;
			loc_q      <= loc_in_wide[LOC_W-1:0];
			best_len_q <= '0;
			best_loc_q <= '0;
			dup_q      <= 1'b0;
		end else if (cmd.cmp_en) begin
			if (is_dup) begin
				dup_q <= 1'b1;
			end
			if (is_better) begin
				best_len_q <= rd_len;
				best_loc_q <= rd_loc;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			found_location <= lookup_hit ? best_wide[FW-1:0] : '0;
			matched_len    <= lookup_hit ? best_len_q : '0;
			priority if (bad_q) begin
				status <= ipv4lpm_pkg::ST_BAD;
			end else if (op_q == ipv4lpm_pkg::OP_LOOKUP) begin
				if (best_len_q != '0) begin
					status <= ipv4lpm_pkg::ST_DONE;
				end else begin
					status <= ipv4lpm_pkg::ST_MISS;
				end
			end else if (dup_q) begin
				status <= ipv4lpm_pkg::ST_DONE;
			end else if (cmd.table_full) begin
				status <= ipv4lpm_pkg::ST_FULL;
			end else begin
				status <= ipv4lpm_pkg::ST_DONE;
			end
		end
	end

endmodule

// File: hw/rtl/ipv4lpm_ctrl.sv
module ipv4lpm_ctrl #(
	parameter int TABLE_ENTRIES = ipv4lpm_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output ipv4lpm_pkg::dp_cmd_t              cmd,
	input  ipv4lpm_pkg::dp_sts_t              sts,
	output logic [$clog2(TABLE_ENTRIES)-1:0]  rd_addr,
	output logic [$clog2(TABLE_ENTRIES)-1:0]  wr_addr
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(TABLE_ENTRIES);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] count_q;
	logic             cmp_q;
	logic             m_tvalid_q;

	logic out_free;
	logic last_idx;
	logic full;

	assign out_free = !m_tvalid_q || m_tready;
	assign last_idx = (CNT_W'(idx_q) == (count_q - 1'b1));
	assign full     = (count_q == CNT_MAX);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign rd_addr  = idx_q;
	assign wr_addr  = count_q[IDX_W-1:0];

	assign cmd.load_in    = s_tvalid && s_tready;
	assign cmd.rd_en      = (state_q == S_SCAN);
	assign cmd.cmp_en     = cmp_q;
	assign cmd.out_load   = (state_q == S_FINISH) && out_free;
	assign cmd.table_full = full;
	assign cmd.write      = cmd.out_load && !sts.bad && !sts.lookup && !sts.dup && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			idx_q      <= '0;
			count_q    <= '0;
			cmp_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			cmp_q <= cmd.rd_en;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.load_in) begin
						idx_q   <= '0;
						state_q <= (count_q == '0) ? S_FINISH : S_SCAN;
					end
				end
				S_SCAN: begin
					if (last_idx) begin
						state_q <= S_DRAIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_DRAIN: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (cmd.out_load) begin
						state_q <= S_IDLE;
					end
					if (cmd.write) begin
						count_q <= count_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("entry count beyond table size");

	a_write_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write |-> cmd.out_load && !full)
		else $error("table write outside result load");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (count_q != '0) && (CNT_W'(idx_q) < count_q))
		else $error("scan address outside filled entries");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> m_tvalid_q)
		else $error("loaded result not presented");

endmodule

// File: hw/rtl/ipv4_longest_prefix_lookup.sv
// ipv4 longest prefix lookup
// input channel s_*: one beat is an insert (tuser = 0) or a lookup (tuser = 1)
// of an ipv4 address, with prefix length and location for inserts
// output channel m_*: exactly one result beat per input beat, in order,
// carrying status, location and length of the longest matching prefix
// each beat scans the filled part of the prefix table one entry per cycle
// through the table's single read port, in the states scan, drain and
// finish, the result being loaded in finish once the output register is free;
// on an empty table the scan and drain are skipped; the next beat is accepted
// the cycle after the result is loaded
// inserts that are new and valid are written into the next free slot as the
// result is loaded; the table fills in order and is never cleared
// reset empties the table at once (fill count to zero) and drops any beat
// in flight; no clearing pass is needed
// a stalled receiver holds the result in the output register; the block
// finishes no further beat until that result is taken, and the input channel
// stays ready only until the next beat is accepted
module ipv4_longest_prefix_lookup #(
	parameter int TABLE_ENTRIES = ipv4lpm_pkg::TABLE_ENTRIES_DEF,
	parameter int LOCATION_BITS = ipv4lpm_pkg::LOCATION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // address[31:0], prefix_len[37:32], location_id[53:38]
	input  logic [0:0]  s_tuser,   // op[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // status[1:0], found_location[17:2], matched_len[23:18]
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);

	ipv4lpm_pkg::dp_cmd_t  cmd;
	ipv4lpm_pkg::dp_sts_t  sts;
	ipv4lpm_pkg::status_t  status;
	logic [IDX_W-1:0]      rd_addr;
	logic [IDX_W-1:0]      wr_addr;
	logic [ipv4lpm_pkg::LOCF_W-1:0] found_location;
	logic [ipv4lpm_pkg::LEN_W-1:0]  matched_len;

	ipv4lpm_ctrl #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts),
		.rd_addr  (rd_addr),
		.wr_addr  (wr_addr)
	);

	ipv4lpm_dp #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.LOCATION_BITS(LOCATION_BITS)
	) u_dp (
		.clk            (clk),
		.cmd            (cmd),
		.sts            (sts),
		.rd_addr        (rd_addr),
		.wr_addr        (wr_addr),
		.op             (s_tuser[0]),
		.address        (s_tdata[31:0]),
		.prefix_len     (s_tdata[37:32]),
		.location_id    (s_tdata[53:38]),
		.status         (status),
		.found_location (found_location),
		.matched_len    (matched_len)
	);

	assign m_tdata = {matched_len, found_location, status};

endmodule

// File: tb/sv/ipv4_longest_prefix_lookup_tb.sv
`timescale 1ns / 100ps

module ipv4_longest_prefix_lookup_tb;

	localparam int N_ENTRIES = ipv4lpm_pkg::TABLE_ENTRIES_DEF;
	localparam int N_RANDOM  = 1450;
	localparam int AW        = ipv4lpm_pkg::ADDR_W;
	localparam int LW        = ipv4lpm_pkg::LEN_W;
	localparam int FW        = ipv4lpm_pkg::LOCF_W;

	typedef struct {
		logic          op;
		logic [AW-1:0] address;
		logic [LW-1:0] plen;
		logic [FW-1:0] loc;
	} lpm_req_t;

	typedef struct {
		ipv4lpm_pkg::status_t status;
		logic [FW-1:0]        loc;
		logic [LW-1:0]        len;
	} lpm_resp_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata  = '0;   // address[31:0], prefix_len[37:32], location_id[53:38]
	logic [0:0]  s_tuser  = '0;   // op[0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;         // status[1:0], found_location[17:2], matched_len[23:18]

	// shadow prefix table
	logic [AW-1:0] tbl_prefix [N_ENTRIES];
	logic [LW-1:0] tbl_len    [N_ENTRIES];
	logic [FW-1:0] tbl_loc    [N_ENTRIES];
	int            tbl_count  = 0;

	lpm_req_t      req_q [$];
	lpm_resp_t     expected_resp_q [$];
	lpm_req_t      cur_req;
	lpm_resp_t     new_resp;
	lpm_resp_t     want;

	// prefixes handed out so far, for lookups that hit and for repeats
	logic [AW-1:0] gen_keys [$];
	logic [LW-1:0] gen_lens [$];

	int src_idle_pct = 17;
	int snk_idle_pct = 71;
	int fail_count   = 0;

	ipv4_longest_prefix_lookup i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	function automatic logic [AW-1:0] net_mask(input logic [LW-1:0] len);
		logic [AW-1:0] ones;
		ones = '1;
		return ones << (AW - int'(len));
	endfunction

	task automatic predict_beat(input lpm_req_t rq, output lpm_resp_t rs);
		logic [AW-1:0] key;
		logic          dup;
		rs.status = ipv4lpm_pkg::ST_DONE;
		rs.loc    = '0;
		rs.len    = '0;
		if (rq.address == '0) begin
			rs.status = ipv4lpm_pkg::ST_BAD;
		end else if (rq.op == ipv4lpm_pkg::OP_INSERT) begin
			if (rq.plen == '0 || rq.plen > ipv4lpm_pkg::MAX_LEN) begin
				rs.status = ipv4lpm_pkg::ST_BAD;
			end else begin
				key = rq.address & net_mask(rq.plen);
				dup = 1'b0;
				for (int i = 0; i < tbl_count; i++)
					if (tbl_len[i] == rq.plen && tbl_prefix[i] == key)
						dup = 1'b1;
				if (!dup) begin
					if (tbl_count >= N_ENTRIES) begin
						rs.status = ipv4lpm_pkg::ST_FULL;
					end else begin
						tbl_prefix[tbl_count] = key;
						tbl_len[tbl_count]    = rq.plen;
						tbl_loc[tbl_count]    = rq.loc;
						tbl_count++;
					end
				end
			end
		end else begin
			for (int i = 0; i < tbl_count; i++) begin
				if ((rq.address & net_mask(tbl_len[i])) == tbl_prefix[i] &&
				    tbl_len[i] > rs.len) begin
					rs.len = tbl_len[i];
					rs.loc = tbl_loc[i];
				end
			end
			if (rs.len == '0)
				rs.status = ipv4lpm_pkg::ST_MISS;
		end
	endtask

	task automatic add_req(input logic op, input logic [AW-1:0] address,
	                       input logic [LW-1:0] plen, input logic [FW-1:0] loc);
		lpm_req_t rq;
		rq.op      = op;
		rq.address = address;
		rq.plen    = plen;
		rq.loc     = loc;
		req_q.push_back(rq);
		if (op == ipv4lpm_pkg::OP_INSERT && address != '0 && plen != '0 &&
		    plen <= ipv4lpm_pkg::MAX_LEN) begin
			gen_keys.push_back(address & net_mask(plen));
			gen_lens.push_back(plen);
		end
	endtask

	task automatic gen_random(input int n);
		int            r;
		int            k;
		logic [AW-1:0] a;
		logic [LW-1:0] l;
		for (int j = 0; j < n; j++) begin
			r = $urandom_range(99);
			if (r < 4) begin
				add_req(1'($urandom_range(1)), '0, 6'($urandom_range(63)), 16'($urandom()));
			end else if (r < 9) begin
				l = ($urandom_range(3) == 0) ? 6'd0 : 6'($urandom_range(63, 33));
				add_req(ipv4lpm_pkg::OP_INSERT, $urandom(), l, 16'($urandom()));
			end else if (r < 40) begin
				if (gen_keys.size() > 0 && $urandom_range(99) < 30) begin
					// same prefix again, other host bits and location
					k = $urandom_range(gen_keys.size() - 1);
					l = gen_lens[k];
					a = gen_keys[k] | ($urandom() & ~net_mask(l));
				end else begin
					case ($urandom_range(3))
						0: l = 6'd8;
						1: l = 6'd16;
						2: l = 6'd24;
						default: l = 6'($urandom_range(32, 1));
					endcase
					a = $urandom();
				end
				add_req(ipv4lpm_pkg::OP_INSERT, a, l, 16'($urandom()));
			end else begin
				if (gen_keys.size() > 0 && $urandom_range(99) < 80) begin
					k = $urandom_range(gen_keys.size() - 1);
					a = gen_keys[k] | ($urandom() & ~net_mask(gen_lens[k]));
				end else begin
					a = $urandom();
				end
				add_req(ipv4lpm_pkg::OP_LOOKUP, a, 6'($urandom_range(63)), 16'($urandom()));
			end
		end
	endtask

	task automatic drain();
		while (req_q.size() != 0 || s_tvalid || expected_resp_q.size() != 0)
			@(posedge clk);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_beat(cur_req, new_resp);
				expected_resp_q.push_back(new_resp);
			end
			if (!s_tvalid || s_tready) begin
				if (req_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					cur_req  = req_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {2'b00, cur_req.loc, cur_req.plen, cur_req.address};
					s_tuser  <= cur_req.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_resp_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result beat: status %0d loc %h len %0d",
						         m_tdata[1:0], m_tdata[17:2], m_tdata[23:18]);
				end else begin
					want = expected_resp_q.pop_front();
					if (m_tdata[1:0] != want.status || m_tdata[17:2] != want.loc ||
					    m_tdata[23:18] != want.len) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: exp %0d/%h/%0d got %0d/%h/%0d",
							         want.status, want.loc, want.len,
							         m_tdata[1:0], m_tdata[17:2], m_tdata[23:18]);
					end
				end
			end
			m_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	initial begin
		#20_000_000;
		$display("ipv4_longest_prefix_lookup regression: fail");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats, starting from an empty table
		add_req(ipv4lpm_pkg::OP_LOOKUP, 32'h0A000001, 6'd0,  16'h0000);
		add_req(ipv4lpm_pkg::OP_INSERT, 32'h00000000, 6'd8,  16'h1111);
		add_req(ipv4lpm_pkg::OP_LOOKUP, 32'h00000000, 6'd0,  16'h0000);
		add_req(ipv4lpm_pkg::OP_INSERT, 32'h0A000000, 6'd0,  16'h2222);
		add_req(ipv4lpm_pkg::OP_INSERT, 32'h0A000000, 6'd33, 16'h3333);
		add_req(ipv4lpm_pkg::OP_INSERT, 32'h0A000000, 6'd63, 16'h4444);
		add_req(ipv4lpm_pkg::OP_INSERT, 32'h0A0B0C0D, 6'd8,  16'h1234);
		add_req(ipv4lpm_pkg::OP_INSERT, 32'h0AFFFFFF, 6'd8,  16'h5555);
		add_req(ipv4lpm_pkg::OP_INSERT, 32'h0A0B0000, 6'd16, 16'hFFFF);
		add_req(ipv4lpm_pkg::OP_INSERT, 32'hFFFFFFFF, 6'd32, 16'h0000);
		add_req(ipv4lpm_pkg::OP_INSERT, 32'h7FFFFFFF, 6'd1,  16'h00AA);
		add_req(ipv4lpm_pkg::OP_INSERT, 32'h80000000, 6'd1,  16'hA5A5);
		add_req(ipv4lpm_pkg::OP_LOOKUP, 32'h0A0B0C0D, 6'd0,  16'h0000);
		add_req(ipv4lpm_pkg::OP_LOOKUP, 32'h0AFF0000, 6'd0,  16'h0000);
		add_req(ipv4lpm_pkg::OP_LOOKUP, 32'hFFFFFFFF, 6'd0,  16'h0000);
		add_req(ipv4lpm_pkg::OP_LOOKUP, 32'hFFFFFFFE, 6'd0,  16'h0000);
		add_req(ipv4lpm_pkg::OP_LOOKUP, 32'h00000001, 6'd0,  16'h0000);
		add_req(ipv4lpm_pkg::OP_INSERT, 32'h0A0B0C0D, 6'd32, 16'hC3C3);
		add_req(ipv4lpm_pkg::OP_LOOKUP, 32'h0A0B0C0D, 6'd0,  16'h0000);
		add_req(ipv4lpm_pkg::OP_LOOKUP, 32'h12345678, 6'd63, 16'hFFFF);
		add_req(ipv4lpm_pkg::OP_INSERT, 32'h0A0B0C0D, 6'd32, 16'h0001);
		add_req(ipv4lpm_pkg::OP_LOOKUP, 32'h0A0B0C0D, 6'd0,  16'h0000);
		drain();

		gen_random(N_RANDOM / 3);
		drain();

		src_idle_pct = 71;
		snk_idle_pct = 17;
		gen_random(N_RANDOM / 3);
		drain();

		src_idle_pct = 0;
		snk_idle_pct = 0;
		gen_random(N_RANDOM - 2 * (N_RANDOM / 3));
		drain();

		repeat (300) @(posedge clk);
		if (fail_count == 0 && expected_resp_q.size() == 0) begin
			$display("ipv4_longest_prefix_lookup regression: pass");
		end else begin
			$display("ipv4_longest_prefix_lookup regression: fail");
		end
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/ipv4lpm_pkg.sv
hw/rtl/ipv4lpm_dp.sv
hw/rtl/ipv4lpm_ctrl.sv
hw/rtl/ipv4_longest_prefix_lookup.sv
tb/sv/ipv4_longest_prefix_lookup_tb.sv
